// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them all.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion that is switched off while reset is high.
`define RSDQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RSDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RSDQ_ASSERT(lbl, clk, rst, prop, msg)
`define RSDQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/rsdq_pkg.sv =====
package rsdq_pkg;

   // Descriptor length in elements.
   localparam int DESC_LEN = 128;

   localparam int ELEM_W = 16;
   localparam int BYTE_W = 8;
   localparam int LANES  = 4;

   localparam int AW     = $clog2(DESC_LEN);
   localparam int CNT_W  = AW + 1;
   localparam int SUM_W  = ELEM_W + AW;

   localparam int NWORDS = (DESC_LEN + LANES - 1) / LANES;
   localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int IDX_W  = WIDX_W + 2;

   // The ratio element * 2^18 / sum never exceeds 2^18.
   localparam int RAT_W  = 19;
   localparam int SUB_W  = (SUM_W + 1 > RAT_W) ? SUM_W + 1 : RAT_W;

   localparam int DIV_STEPS  = RAT_W;
   localparam int SQRT_STEPS = (RAT_W + 1) / 2;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   // Clamp a root to one byte.
   function automatic logic [BYTE_W-1:0] sat_byte(input logic [RAT_W-1:0] root);
      logic [BYTE_W-1:0] res;
      res = (|root[RAT_W-1:BYTE_W]) ? {BYTE_W{1'b1}} : root[BYTE_W-1:0];
      return res;
   endfunction

endpackage

// ===== rtl/core/rsdq_ram.sv =====
module rsdq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rootsift_descriptor_quantizer_top.sv =====
// Sequencing: the last element of a descriptor starts quantization; each element then passes
// through a RAM read (issue, fetch), the divide and the square root; a word is ready once
// its four lanes are done. Throughput: elements other than the last are taken one per cycle;
// the last one closes the input until the last result word of the descriptor has been taken.
// Reset (synchronous, active high) clears the sum, the count and the sequencer; the element
// store is not cleared, since every entry is written before it is read.
`include "assert_macros.svh"

module rootsift_descriptor_quantizer_top
   import rsdq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Input word: one descriptor element.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ELEM_W-1:0]        req_tdata,   // [15:0] element_value
   // Result word: four quantized bytes.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [LANES*BYTE_W-1:0]  rsp_tdata,   // [7:0] byte_zero, [15:8] byte_one,
                                                 // [23:16] byte_two, [31:24] byte_three
   output logic                     rsp_tlast    // last_word
);

   // The sequencer walks every element through one shared subtractor: first a
   // restoring divide of element * 2^18 by the sum, then a bitwise integer square
   // root of the quotient. The same remainder and quotient registers serve both.
   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_ISSUE = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_SQRT  = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [SUB_W-1:0]            rem_ff, rem_in;
   logic [RAT_W-1:0]            quo_ff, quo_in;
   logic [LANES-1:0][BYTE_W-1:0] word_ff, word_in;

   logic                        req_fire;
   logic                        ram_rd_en;
   logic [ELEM_W-1:0]           ram_rd_data;

   // Shared unit.
   logic [SUB_W-1:0]            opa, opb;
   logic [SUB_W:0]              diff;
   logic                        ge;
   logic [STEP_W-1:0]           sqrt_sh;
   logic [RAT_W-1:0]            sqrt_bit;
   logic [RAT_W-1:0]            root_next;
   logic                        byte_done;
   logic [BYTE_W-1:0]           byte_val;
   logic                        idx_valid;
   logic                        word_last;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = word_ff;
   assign word_last  = (idx_ff[IDX_W-1:2] == WIDX_W'(NWORDS - 1));
   assign rsp_tlast  = word_last;
   assign idx_valid  = ({1'b0, idx_ff} < (IDX_W + 1)'(DESC_LEN));

   rsdq_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DESC_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // The square-root trial bit walks down by powers of four from 2^18.
   assign sqrt_sh  = STEP_W'(RAT_W - 1) - {step_ff[STEP_W-2:0], 1'b0};
   assign sqrt_bit = {{(RAT_W-1){1'b0}}, 1'b1} << sqrt_sh;

   always_comb begin
      if (state_ff == ST_DIV) begin
         // The first step compares the element itself; later steps shift in a zero.
         opa = (step_ff == '0) ? rem_ff : {rem_ff[SUB_W-2:0], 1'b0};
         opb = SUB_W'(sum_ff);
      end else begin
         // In the root, quo_ff holds the partial root; its bits never meet the trial bit.
         opa = rem_ff;
         opb = SUB_W'(quo_ff | sqrt_bit);
      end
      diff = {1'b0, opa} - {1'b0, opb};
      ge   = ~diff[SUB_W];
   end

   assign root_next = ge ? ((quo_ff >> 1) | sqrt_bit) : (quo_ff >> 1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      word_in   = word_ff;
      ram_rd_en = 1'b0;
      byte_done = 1'b0;
      byte_val  = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               sum_in = sum_ff + SUM_W'(req_tdata);
               if (cnt_ff == CNT_W'(DESC_LEN - 1)) begin
                  cnt_in   = '0;
                  state_in = ST_ISSUE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            if (idx_valid) begin
               ram_rd_en = 1'b1;
               state_in  = ST_FETCH;
            end else begin
               // Lanes past the end of the descriptor carry zero.
               byte_done = 1'b1;
            end
         end
         ST_FETCH: begin
            rem_in   = SUB_W'(ram_rd_data);
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               // The finished quotient becomes the radicand.
               rem_in   = SUB_W'({quo_ff[RAT_W-2:0], ge});
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               rem_in  = ge ? diff[SUB_W-1:0] : opa;
               quo_in  = {quo_ff[RAT_W-2:0], ge};
               step_in = step_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            rem_in  = ge ? diff[SUB_W-1:0] : rem_ff;
            quo_in  = root_next;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               byte_done = 1'b1;
               // A zero sum gives zero for every element.
               byte_val  = (sum_ff == '0) ? '0 : sat_byte(root_next);
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (word_last) begin
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (byte_done) begin
         word_in[idx_ff[1:0]] = byte_val;
         if (idx_ff[1:0] == 2'd3) begin
            state_in = ST_SEND;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_ISSUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      word_ff <= word_in;
   end

   // The input is never open while a result word is on offer.
   `RSDQ_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid), "input open during output")
   // The final element of a descriptor closes the input.
   `RSDQ_ASSERT(a_last_closes, clock, reset, (req_fire && (cnt_ff == CNT_W'(DESC_LEN - 1))) |=> !req_tready, "input stayed open after last element")
   // Once the last word is taken the block is ready for the next descriptor with a clean sum.
   `RSDQ_ASSERT(a_reopen, clock, reset, (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && (sum_ff == '0) && (cnt_ff == '0)), "not reopened after last word")
   // Reset always leaves the block waiting for input.
   `RSDQ_ASSERT_ALWAYS(a_reset_state, clock, reset |=> (req_tready && !rsp_tvalid), "reset did not return to load")

endmodule
